FILE: hw/rtl/mii_register_emulator_defines.svh
// Assertion macros shared by the checker of the MII register emulator.
`ifndef MII_REGISTER_EMULATOR_DEFINES_SVH
`define MII_REGISTER_EMULATOR_DEFINES_SVH

// Same-cycle implication, idle while reset is held.
`define MRE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle while reset is held.
`define MRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mre_pkg.sv
// Package of the MII register emulator: codes, constants and shared types.
`timescale 1ns / 1ps

package mre_pkg;

  // Stream widths
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;

  // Defaults
  localparam int         NUM_PHY_PORTS_DEF = 2;
  localparam logic [1:0] PHY_COUNT_RESET   = 2'd2;
  localparam logic [7:0] CTRL_RESET        = 8'h9F;
  localparam logic [7:0] RESTART_RESET     = 8'h00;
  localparam logic [7:0] STATUS_RESET      = 8'h00;

  // Opcodes
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // Clause-22 register numbers
  localparam logic [4:0] REG_BMCR    = 5'd0;
  localparam logic [4:0] REG_BMSR    = 5'd1;
  localparam logic [4:0] REG_PHYSID1 = 5'd2;
  localparam logic [4:0] REG_PHYSID2 = 5'd3;
  localparam logic [4:0] REG_ADV     = 5'd4;
  localparam logic [4:0] REG_LPA     = 5'd5;

  // Fixed register words
  localparam logic [15:0] PHY_ID1_WORD = 16'h0022;
  localparam logic [15:0] PHY_ID2_WORD = 16'h1430;
  localparam logic [15:0] NO_READ_WORD = 16'hFFFF;

  // Command from the input stage to the per-port state
  typedef struct packed {
    logic        commit;
    logic        port_ok;
    logic [1:0]  op;
    logic [1:0]  port;
    logic [4:0]  reg_addr;
    logic [15:0] wdata;
  } mre_cmd_t;

  // The three bytes of one port
  typedef struct packed {
    logic [7:0] control;
    logic [7:0] restart;
    logic [7:0] status;
  } mre_bytes_t;

endpackage

FILE: hw/rtl/mre_port_state.sv
// Per-port control, restart and status bytes with their write-update logic.
`timescale 1ns / 1ps

module mre_port_state import mre_pkg::*; #(
  parameter int NUM_PHY_PORTS = NUM_PHY_PORTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  mre_cmd_t   cmd,
  output mre_bytes_t cur_bytes,
  output mre_bytes_t nxt_bytes
);

  localparam int IDX_W = (NUM_PHY_PORTS > 1) ? $clog2(NUM_PHY_PORTS) : 1;

  logic [7:0] ctrl_r    [NUM_PHY_PORTS];
  logic [7:0] restart_r [NUM_PHY_PORTS];
  logic [7:0] status_r  [NUM_PHY_PORTS];

  logic [IDX_W+1:0] port_ext;
  logic [IDX_W-1:0] idx;
  logic [7:0]       ctrl_nxt;
  logic [7:0]       restart_nxt;
  logic [7:0]       status_nxt;

  // Index of the addressed port; parked at 0 when the port is not served
  assign port_ext = {{IDX_W{1'b0}}, cmd.port};
  assign idx      = cmd.port_ok ? port_ext[IDX_W-1:0] : '0;

  assign cur_bytes.control = ctrl_r[idx];
  assign cur_bytes.restart = restart_r[idx];
  assign cur_bytes.status  = status_r[idx];

  // Bit mapping of MII writes and status loads
  always_comb begin
    ctrl_nxt    = cur_bytes.control;
    restart_nxt = cur_bytes.restart;
    status_nxt  = cur_bytes.status;
    if (cmd.op == OP_WRITE) begin
      if (cmd.reg_addr == REG_BMCR) begin
        ctrl_nxt    = {cmd.wdata[12], cmd.wdata[13], cmd.wdata[8], cur_bytes.control[4:0]};
        restart_nxt = {cur_bytes.restart[7:6], cmd.wdata[9], cur_bytes.restart[4],
                       cmd.wdata[11], cur_bytes.restart[2:0]};
      end else if (cmd.reg_addr == REG_ADV) begin
        ctrl_nxt = {cur_bytes.control[7:4], cmd.wdata[8:5]};
      end
    end else if (cmd.op == OP_STATUS) begin
      status_nxt = cmd.wdata[7:0];
    end
  end

  assign nxt_bytes.control = ctrl_nxt;
  assign nxt_bytes.restart = restart_nxt;
  assign nxt_bytes.status  = status_nxt;

  // Byte storage, updated when the item leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PHY_PORTS; i++) begin
        ctrl_r[i]    <= CTRL_RESET;
        restart_r[i] <= RESTART_RESET;
        status_r[i]  <= STATUS_RESET;
      end
    end else if (cmd.commit && cmd.port_ok) begin
      ctrl_r[idx]    <= ctrl_nxt;
      restart_r[idx] <= restart_nxt;
      status_r[idx]  <= status_nxt;
    end
  end

endmodule

FILE: hw/rtl/mre_read_mux.sv
// Builds the 16-bit clause-22 read word from the addressed port's bytes.
`timescale 1ns / 1ps

module mre_read_mux import mre_pkg::*; (
  input  mre_cmd_t    cmd,
  input  mre_bytes_t  bytes,
  output logic [15:0] read_data
);

  logic [7:0]  c;
  logic [7:0]  r;
  logic [7:0]  s;
  logic [15:0] word;

  assign c = bytes.control;
  assign r = bytes.restart;
  assign s = bytes.status;

  // Register word decode
  always_comb begin
    case (cmd.reg_addr)
      REG_BMCR:    word = {2'b00, c[6], c[7], r[3], 1'b0, r[5], c[5], 8'h00};
      REG_BMSR:    word = 16'h7808 | {10'd0, s[6], 2'b00, s[5], 2'b00};
      REG_PHYSID1: word = PHY_ID1_WORD;
      REG_PHYSID2: word = PHY_ID2_WORD;
      REG_ADV:     word = {7'd0, c[3:0], 5'h01};
      // ack bit 14 set once the partner advertises anything
      REG_LPA:     word = {1'b0, |s[3:0], 5'd0, s[3:0], 5'h1F};
      default:     word = NO_READ_WORD;
    endcase
  end

  // Only a read of a served port returns a register word
  assign read_data = (cmd.port_ok && cmd.op == OP_READ) ? word : NO_READ_WORD;

endmodule

FILE: hw/rtl/mii_register_emulator.sv
// An input transfer passes the input register, then the result register, on its way to the result.
// Throughput: one item per cycle; out_tready low stalls the result register,
//   then the input register, and in_tready follows.
// Reset (rst_n low, synchronous): control bytes 0x9F, restart and status bytes 0,
//   phy_port_count 2, both stages empty.
`timescale 1ns / 1ps

module mii_register_emulator import mre_pkg::*; #(
  parameter int NUM_PHY_PORTS = NUM_PHY_PORTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration
  input  logic                   cfg_wr_en,
  input  logic [1:0]             cfg_wr_data,  // phy_port_count
  // Request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,     // port[1:0], reg_addr[6:2], write_data[22:7]
  input  logic [IN_TUSER_W-1:0]  in_tuser,     // opcode[1:0]
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata     // read_data[15:0], port_control[23:16],
                                               // port_restart[31:24]
);

  localparam logic [3:0] NUM_PORTS_V = 4'(NUM_PHY_PORTS);

  logic [1:0]  phy_count_r;

  logic        s1_valid_r;
  logic [1:0]  s1_op_r;
  logic [1:0]  s1_port_r;
  logic [4:0]  s1_reg_r;
  logic [15:0] s1_wdata_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic        out_adv;
  logic        s1_adv;
  logic        port_ok;
  mre_cmd_t    cmd;
  mre_bytes_t  cur_bytes;
  mre_bytes_t  nxt_bytes;
  logic [15:0] read_data;
  logic [7:0]  rep_control;
  logic [7:0]  rep_restart;

  // Flow control between the two stages
  assign out_adv   = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_adv;
  assign in_tready = !s1_valid_r || out_adv;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phy_count_r <= PHY_COUNT_RESET;
    end else if (cfg_wr_en) begin
      phy_count_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r    <= in_tuser[1:0];
      s1_port_r  <= in_tdata[1:0];
      s1_reg_r   <= in_tdata[6:2];
      s1_wdata_r <= in_tdata[22:7];
    end
  end

  // Port is served if below both the configured count and the built-in count
  assign port_ok = ({2'b00, s1_port_r} < NUM_PORTS_V) && (s1_port_r < phy_count_r);

  assign cmd.commit   = s1_adv;
  assign cmd.port_ok  = port_ok;
  assign cmd.op       = s1_op_r;
  assign cmd.port     = s1_port_r;
  assign cmd.reg_addr = s1_reg_r;
  assign cmd.wdata    = s1_wdata_r;

  mre_port_state #(
    .NUM_PHY_PORTS (NUM_PHY_PORTS)
  ) u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cur_bytes (cur_bytes),
    .nxt_bytes (nxt_bytes)
  );

  mre_read_mux u_read (
    .cmd       (cmd),
    .bytes     (cur_bytes),
    .read_data (read_data)
  );

  // Reported bytes are the post-update values, zero for an unserved port
  assign rep_control = port_ok ? nxt_bytes.control : 8'h00;
  assign rep_restart = port_ok ? nxt_bytes.restart : 8'h00;

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {rep_restart, rep_control, read_data};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: hw/rtl/mre_checker.sv
// Port-level checker of the MII register emulator and its bind.
`timescale 1ns / 1ps
`include "mii_register_emulator_defines.svh"

module mre_checker import mre_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds
  `MRE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // With the result register empty the input side never stalls
  `MRE_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready, "input stalled with empty output")

  // Nothing comes out in the cycle after reset
  `MRE_ASSERT_NOW(a_empty_after_reset, clk, rst_n, $past(!rst_n), !out_tvalid, "result valid right after reset")

endmodule

bind mii_register_emulator mre_checker u_mre_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/mii_result_checker.sv
// Result checker for the MII register emulator: tracks port bytes and checks every result.
`timescale 1ns / 1ps

module mii_result_checker import mre_pkg::*; #(
  parameter int N_PHY = NUM_PHY_PORTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [1:0]             cfg_wr_data,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count,
  output int                     pending
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [15:0] read_data;
    logic [7:0]  control;
    logic [7:0]  restart;
  } mii_reply_t;

  // Shadow copy of the per-port bytes and the PHY count
  logic [7:0] ctrl_shadow   [N_PHY];
  logic [7:0] restart_shadow[N_PHY];
  logic [7:0] status_shadow [N_PHY];
  logic [1:0] phy_count;

  mii_reply_t replies_due[$];
  int         mismatch_count;

  // Build the clause-22 word for a read of one port
  function automatic logic [15:0] mii_word(int p, logic [4:0] ra);
    logic [7:0]  c;
    logic [7:0]  r;
    logic [7:0]  s;
    logic [15:0] d;
    c = ctrl_shadow[p];
    r = restart_shadow[p];
    s = status_shadow[p];
    case (ra)
      REG_BMCR: begin
        d = {2'b00, c[6], c[7], r[3], 1'b0, r[5], c[5], 8'h00};
      end
      REG_BMSR: begin
        d = 16'h7808;
        d[5] = s[6];
        d[2] = s[5];
      end
      REG_PHYSID1: d = PHY_ID1_WORD;
      REG_PHYSID2: d = PHY_ID2_WORD;
      REG_ADV: begin
        d = 16'h0001;
        d[8:5] = c[3:0];
      end
      REG_LPA: begin
        d = 16'h001F;
        d[8:5] = s[3:0];
        // ack bit set once the partner advertises anything
        if (|d[8:5]) d[14] = 1'b1;
      end
      default: d = NO_READ_WORD;
    endcase
    return d;
  endfunction

  // Apply one request to the shadow bytes and return the result it should give
  function automatic mii_reply_t compute_reply(logic [1:0] op, logic [1:0] port,
                                               logic [4:0] ra, logic [15:0] wd);
    mii_reply_t rep;
    bit         served;
    int         p;
    p = port;
    served = (port < phy_count) && (p < N_PHY);
    rep.read_data = NO_READ_WORD;
    rep.control   = 8'h00;
    rep.restart   = 8'h00;
    if (served) begin
      case (op)
        OP_READ: rep.read_data = mii_word(p, ra);
        OP_WRITE: begin
          if (ra == REG_BMCR) begin
            ctrl_shadow[p][7]    = wd[12];
            ctrl_shadow[p][6]    = wd[13];
            ctrl_shadow[p][5]    = wd[8];
            restart_shadow[p][5] = wd[9];
            restart_shadow[p][3] = wd[11];
          end else if (ra == REG_ADV) begin
            ctrl_shadow[p][3:0] = wd[8:5];
          end
        end
        OP_STATUS: status_shadow[p] = wd[7:0];
        default: ;
      endcase
      rep.control = ctrl_shadow[p];
      rep.restart = restart_shadow[p];
    end
    return rep;
  endfunction

  task automatic report_field(string field, logic [15:0] want, logic [15:0] got);
    mismatch_count++;
    fail_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
  endtask

  // Compare one result transfer with the oldest expectation
  task automatic check_reply(logic [OUT_TDATA_W-1:0] data);
    mii_reply_t want;
    if (replies_due.size() == 0) begin
      fail_count++;
      $display("%0t: result %h with nothing outstanding", $realtime, data);
    end else begin
      want = replies_due.pop_front();
      if (data[15:0] !== want.read_data) report_field("read_data", want.read_data, data[15:0]);
      if (data[23:16] !== want.control) report_field("port_control", want.control, data[23:16]);
      if (data[31:24] !== want.restart) report_field("port_restart", want.restart, data[31:24]);
    end
  endtask

  initial begin
    fail_count     = 0;
    pending        = 0;
    mismatch_count = 0;
  end

  // Sample both channels and the config port at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (ctrl_shadow[i]) begin
        ctrl_shadow[i]    = CTRL_RESET;
        restart_shadow[i] = RESTART_RESET;
        status_shadow[i]  = STATUS_RESET;
      end
      phy_count = PHY_COUNT_RESET;
      replies_due.delete();
    end else begin
      if (cfg_wr_en) phy_count = cfg_wr_data;
      if (in_tvalid && in_tready)
        replies_due.push_back(compute_reply(in_tuser[1:0], in_tdata[1:0], in_tdata[6:2],
                                            in_tdata[22:7]));
      if (out_tvalid && out_tready) check_reply(out_tdata);
    end
    pending = replies_due.size();
  end

endmodule

FILE: tb/tb_top.sv
// Top of the MII register emulator testbench: clock, reset, request and ready stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;
  import mre_pkg::*;

  localparam int RESET_CYCLES   = 6;
  localparam int IDLE_MAX       = 16;
  localparam int LONG_HOLD      = 80;
  localparam int LATENCY        = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_PHASES       = 6;
  localparam int PHASE_ITEMS    = 275;

  localparam logic [4:0] REG_FIRST_UNUSED = 5'd6;
  localparam logic [4:0] REG_LAST         = 5'd31;

  typedef enum int {PACE_FULL, PACE_RANDOM, PACE_BURSTY} pace_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [1:0]             cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // port[1:0], reg_addr[6:2], write_data[22:7]
  logic [IN_TUSER_W-1:0]  in_tuser;   // opcode[1:0]
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // read_data[15:0], port_control[23:16], port_restart[31:24]

  int    fail_count;
  int    pending;
  int    quiet_cycles;
  pace_t send_pace;
  pace_t recv_pace;
  bit    hold_off_req;

  // Per-phase PHY count and pacing
  logic [1:0] phase_count[N_PHASES] = '{2'd2, 2'd1, 2'd3, 2'd0, 2'd2, 2'd1};
  pace_t      phase_send [N_PHASES] = '{PACE_FULL, PACE_FULL, PACE_RANDOM, PACE_RANDOM,
                                        PACE_BURSTY, PACE_RANDOM};
  pace_t      phase_recv [N_PHASES] = '{PACE_FULL, PACE_RANDOM, PACE_FULL, PACE_RANDOM,
                                        PACE_BURSTY, PACE_BURSTY};

  mii_register_emulator #(.NUM_PHY_PORTS(NUM_PHY_PORTS_DEF)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  mii_result_checker #(.N_PHY(NUM_PHY_PORTS_DEF)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int draw_gap(pace_t pace);
    case (pace)
      PACE_FULL:   return 0;
      PACE_RANDOM: return $urandom_range(0, IDLE_MAX);
      default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(1, IDLE_MAX) : 0;
    endcase
  endfunction

  // Offer one request; called and returning at a falling edge
  task automatic send_item(logic [1:0] op, logic [1:0] port, logic [4:0] ra, logic [15:0] wd);
    int gap;
    gap = draw_gap(send_pace);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'($urandom);
      in_tuser  <= IN_TUSER_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, wd, ra, port};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 1) @(negedge clk);
  endtask

  task automatic write_phy_count(logic [1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly served ports and known registers, with writes often read back
  task automatic random_item();
    int         pick;
    logic [1:0] op;
    logic [1:0] port;
    logic [4:0] ra;
    pick = $urandom_range(0, 99);
    op   = (pick < 45) ? OP_READ : (pick < 75) ? OP_WRITE : (pick < 90) ? OP_STATUS : OP_NOP;
    port = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'($urandom_range(0, 1));
    ra   = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 5));
    send_item(op, port, ra, 16'($urandom));
    if (op == OP_WRITE && $urandom_range(0, 1) == 1)
      send_item(OP_READ, port, ra, 16'($urandom));
  endtask

  // Result side ready pattern, with one long hold when requested
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        gap = LONG_HOLD;
        hold_off_req = 1'b0;
      end else begin
        gap = draw_gap(recv_pace);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Watchdog: cycles with no transfer and no config write
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Main stimulus
  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    quiet_cycles = 0;
    hold_off_req = 1'b0;
    send_pace    = PACE_RANDOM;
    recv_pace    = PACE_RANDOM;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values of every register, then unknown registers
    send_item(OP_READ, 2'd0, REG_BMCR, 16'h0000);
    send_item(OP_READ, 2'd0, REG_BMSR, 16'hFFFF);
    send_item(OP_READ, 2'd1, REG_PHYSID1, 16'h0000);
    send_item(OP_READ, 2'd1, REG_PHYSID2, 16'h0000);
    send_item(OP_READ, 2'd0, REG_ADV, 16'h0000);
    send_item(OP_READ, 2'd0, REG_LPA, 16'h0000);
    send_item(OP_READ, 2'd0, REG_FIRST_UNUSED, 16'h0000);
    send_item(OP_READ, 2'd1, REG_LAST, 16'hFFFF);
    // BMCR and ADVERTISE writes at all-ones and all-zeros
    send_item(OP_WRITE, 2'd0, REG_BMCR, 16'hFFFF);
    send_item(OP_READ, 2'd0, REG_BMCR, 16'h0000);
    send_item(OP_WRITE, 2'd1, REG_BMCR, 16'h0000);
    send_item(OP_READ, 2'd1, REG_BMCR, 16'h0000);
    send_item(OP_WRITE, 2'd0, REG_ADV, 16'h0000);
    send_item(OP_READ, 2'd0, REG_ADV, 16'h0000);
    send_item(OP_WRITE, 2'd1, REG_ADV, 16'hFFFF);
    // write to a read-only register is dropped
    send_item(OP_WRITE, 2'd0, REG_PHYSID1, 16'hFFFF);
    // status load keeps only the low byte, reg_addr ignored
    send_item(OP_STATUS, 2'd0, REG_LAST, 16'hFFFF);
    send_item(OP_READ, 2'd0, REG_BMSR, 16'h0000);
    send_item(OP_READ, 2'd0, REG_LPA, 16'h0000);
    // link up without partner abilities: no ack bit
    send_item(OP_STATUS, 2'd1, REG_BMCR, 16'h0060);
    send_item(OP_READ, 2'd1, REG_LPA, 16'h0000);
    send_item(OP_NOP, 2'd0, REG_BMCR, 16'hFFFF);
    // ports without a PHY
    send_item(OP_READ, 2'd2, REG_BMCR, 16'h0000);
    send_item(OP_WRITE, 2'd3, REG_BMCR, 16'hFFFF);
    send_item(OP_STATUS, 2'd2, REG_BMSR, 16'h00FF);

    // Random phases, each behind a PHY count write
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_phy_count(phase_count[ph]);
      send_pace = phase_send[ph];
      recv_pace = phase_recv[ph];
      // back up the result side while requests keep coming
      if (ph == 1) hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) random_item();
    end

    drain();
    repeat (LATENCY + 4) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
